// ===== src/cb_pkg.sv =====
package cb_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int LABEL_BITS = 20;
  localparam int COUNT_BITS = 20;
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int WID_BITS   = COL_BITS + 1;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [WID_BITS-1:0]   wid_t;

  localparam label_t LABEL_MAX = '1;
  localparam count_t COUNT_MAX = '1;
  localparam wid_t   WID_MAX   = WID_BITS'(MAX_COLS);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_UNROT,
    ST_REROT
  } cb_state_t;

  // control broadcast to every cell of the label line
  typedef struct packed {
    logic   clear;
    logic   step;
    logic   ren_en;
    label_t ren_from;
    label_t ren_to;
    wid_t   len;
    label_t tail;
  } cell_ctl_t;

endpackage

// ===== src/cb_cell.sv =====
module cb_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  cb_pkg::cell_ctl_t ctl,
  input  cb_pkg::col_t      cell_idx,
  input  cb_pkg::label_t    nb_in,
  output cb_pkg::label_t    q
);
  import cb_pkg::*;

  label_t val_r;
  label_t val_nxt;
  label_t self_ren;
  label_t nb_ren;
  wid_t   pos;

  assign pos      = WID_BITS'(cell_idx) + WID_BITS'(1);
  assign self_ren = (ctl.ren_en && val_r == ctl.ren_from) ? ctl.ren_to : val_r;
  assign nb_ren   = (ctl.ren_en && nb_in == ctl.ren_from) ? ctl.ren_to : nb_in;

  always_comb begin
    val_nxt = self_ren;
    if (ctl.clear) begin
      val_nxt = '0;
    end else if (ctl.step) begin
      if (pos < ctl.len) begin
        val_nxt = nb_ren;
      end else if (pos == ctl.len) begin
        val_nxt = ctl.tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

// ===== src/count_8connected_blobs.sv =====
// Counts 8-connected foreground blobs in a binary image streamed in raster
// order, one pixel per transfer; in_tlast marks the frame's last pixel, and
// that pixel's transfer yields one out transfer carrying the blob count.
// Pixels are taken one per clock. The label line is a row of MAX_COLS cells
// that rotates by one cell per pixel over the active row width; a merge is a
// compare-and-replace done in the same clock in every cell. When row_width
// has changed since the last pixel (clamped to 1..MAX_COLS), the next pixel
// waits with in_tready low while the line is realigned one cell per clock,
// first unrotated at the old width, then rerotated at the new width.
// in_tready also drops while a count waits and out_tready is low.
// Labels and count saturate at their width; the stores clear after tlast.
module count_8connected_blobs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [0] pixel_set, rest zero
  input  logic                    in_tlast,   // frame_end
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [23:0]             out_tdata,  // [19:0] component_count, rest zero
  input  logic                    cfg_we,
  input  logic [cb_pkg::WID_BITS-1:0] cfg_wdata // row_width
);
  import cb_pkg::*;

  cb_state_t state_r, state_nxt;
  wid_t      row_width_r;
  wid_t      wid_act;
  wid_t      lw_r, lw_nxt;       // width the line layout follows
  wid_t      tw_r, tw_nxt;       // target width during realign
  col_t      rot_r, rot_nxt;     // line rotation == clamped column
  wid_t      col_r, col_nxt;     // column as the frame counts it
  col_t      cnt_r, cnt_nxt;
  label_t    left_r, left_nxt;
  label_t    ul_r, ul_nxt;
  label_t    nl_r, nl_nxt;
  count_t    blob_r, blob_nxt;
  logic      out_valid_r, out_valid_nxt;
  count_t    out_cnt_r, out_cnt_nxt;

  label_t    cell_q [MAX_COLS];
  cell_ctl_t ctl;

  logic      in_acc;
  logic      pix;
  label_t    left_e, ul_e, up, ur, cur_a, cur_b, cur, up_fix, nl_inc;
  logic      ur_hit, merge, new_lbl;
  count_t    blob_step;
  wid_t      col_p1;
  col_t      tw_col;

  assign wid_act = (row_width_r == '0) ? WID_BITS'(1) :
                   (row_width_r > WID_MAX) ? WID_MAX : row_width_r;

  assign in_tready = (state_r == ST_RUN) && (lw_r == wid_act) &&
                     (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign pix       = in_tdata[0];

  // labeling of the current pixel
  assign left_e = (rot_r == '0) ? '0 : left_r;
  assign ul_e   = (rot_r == '0) ? '0 : ul_r;
  assign up     = cell_q[0];
  assign col_p1 = WID_BITS'(rot_r) + WID_BITS'(1);
  assign ur     = (col_p1 < lw_r) ? cell_q[1] : '0;

  always_comb begin
    cur_a = '0;
    if (pix) begin
      if (left_e != '0) cur_a = left_e;
      if (up != '0)     cur_a = up;
      if (ul_e != '0)   cur_a = ul_e;
    end
  end

  assign ur_hit  = pix && (ur != '0) && (ur != cur_a);
  assign merge   = ur_hit && (cur_a != '0);
  assign cur_b   = (ur_hit && cur_a == '0) ? ur : cur_a;
  assign up_fix  = (merge && up == ur) ? cur_a : up;
  assign new_lbl = pix && (cur_b == '0);
  assign nl_inc  = (nl_r < LABEL_MAX) ? nl_r + label_t'(1) : nl_r;
  assign cur     = new_lbl ? nl_inc : cur_b;

  always_comb begin
    blob_step = blob_r;
    if (merge && blob_r != '0) blob_step = blob_r - count_t'(1);
    if (new_lbl && blob_r < COUNT_MAX) blob_step = blob_r + count_t'(1);
  end

  assign tw_col = (col_r < tw_r) ? col_r[COL_BITS-1:0] : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (lw_r != wid_act) state_nxt = ST_UNROT;
      end
      ST_UNROT: begin
        if (cnt_r == '0) state_nxt = ST_REROT;
      end
      ST_REROT: begin
        if (cnt_r == '0) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // outputs and datapath
  always_comb begin
    lw_nxt        = lw_r;
    tw_nxt        = tw_r;
    rot_nxt       = rot_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    ul_nxt        = ul_r;
    nl_nxt        = nl_r;
    blob_nxt      = blob_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ctl           = '0;
    ctl.len       = lw_r;
    ctl.tail      = cell_q[0];
    case (state_r)
      ST_RUN: begin
        if (lw_r != wid_act) begin
          tw_nxt  = wid_act;
          cnt_nxt = (rot_r == '0) ? '0 : COL_BITS'(lw_r - WID_BITS'(rot_r));
        end else if (in_acc) begin
          ctl.step     = 1'b1;
          ctl.ren_en   = merge;
          ctl.ren_from = ur;
          ctl.ren_to   = cur_a;
          ctl.tail     = cur;
          if (in_tlast) begin
            ctl.clear     = 1'b1;
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = blob_step;
            rot_nxt       = '0;
            col_nxt       = '0;
            left_nxt      = '0;
            ul_nxt        = '0;
            nl_nxt        = '0;
            blob_nxt      = '0;
          end else begin
            col_nxt  = col_p1;
            rot_nxt  = (col_p1 == lw_r) ? '0 : rot_r + col_t'(1);
            left_nxt = cur;
            ul_nxt   = up_fix;
            nl_nxt   = new_lbl ? nl_inc : nl_r;
            blob_nxt = blob_step;
          end
        end
      end
      ST_UNROT: begin
        if (cnt_r == '0) begin
          cnt_nxt = tw_col;
        end else begin
          ctl.step = 1'b1;
          cnt_nxt  = cnt_r - col_t'(1);
        end
      end
      ST_REROT: begin
        ctl.len = tw_r;
        if (cnt_r == '0) begin
          lw_nxt  = tw_r;
          rot_nxt = tw_col;
        end else begin
          ctl.step = 1'b1;
          cnt_nxt  = cnt_r - col_t'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      row_width_r <= WID_MAX;
      lw_r        <= WID_MAX;
      tw_r        <= WID_MAX;
      rot_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      left_r      <= '0;
      ul_r        <= '0;
      nl_r        <= '0;
      blob_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) row_width_r <= cfg_wdata;
      lw_r        <= lw_nxt;
      tw_r        <= tw_nxt;
      rot_r       <= rot_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      ul_r        <= ul_nxt;
      nl_r        <= nl_nxt;
      blob_r      <= blob_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_cnt_r};

  // label line: on a step, cell i takes cell i+1 while i+1 is below the layout width; cell width-1 takes the tail
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    label_t nb;
    if (i < MAX_COLS - 1) begin : g_nb
      assign nb = cell_q[i+1];
    end else begin : g_end
      assign nb = '0;
    end
    cb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cell_idx (COL_BITS'(i)),
      .nb_in    (nb),
      .q        (cell_q[i])
    );
  end

  a_rot_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    WID_BITS'(rot_r) < lw_r)
    else $error("rotation outside layout width");

  a_lw_range: assert property (@(posedge clk) disable iff (!rst_n)
    lw_r != '0 && lw_r <= WID_MAX)
    else $error("layout width out of range");

  a_frame_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> out_tvalid && rot_r == '0 && blob_r == '0)
    else $error("frame end did not post count and clear");

  a_realign_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REROT && cnt_r == '0 |=> lw_r == $past(tw_r))
    else $error("realign did not adopt target width");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cb_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int SETTLE       = 8;      // slack after the last transfer

  typedef struct packed {
    logic set;
    logic last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] pixel_set, rest zero
  logic        in_tlast;   // frame_end
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [19:0] component_count, rest zero
  logic        cfg_we;
  logic [WID_BITS-1:0] cfg_wdata;

  count_8connected_blobs i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_wdata
  );

  // pixels waiting to go out, blob counts waiting to come back
  pixel_t pixel_q[$];
  count_t count_q[$];
  int     errors    = 0;
  int     hold_left = 0;   // set by the sequencer, counted down by the sink
  bit     quiet     = 0;   // no idling in the final stretch
  bit     paused    = 0;
  int     half_q;

  // ---------------------------------------------------------------------
  // Blob counter mirror: label line, neighbor labels, counters, width.
  // ---------------------------------------------------------------------
  label_t lbl_line[MAX_COLS];
  label_t lbl_left, lbl_upleft, lbl_next;
  count_t blobs;
  int     col_pos;
  logic [WID_BITS-1:0] width_reg;

  task automatic clear_labels();
    foreach (lbl_line[k]) lbl_line[k] = '0;
    lbl_left = '0; lbl_upleft = '0; lbl_next = '0;
    blobs = '0; col_pos = 0;
  endtask

  task automatic count_pixel(pixel_t px);
    int     w, c;
    label_t up, ur, cur;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
    if (col_pos >= w) col_pos = 0;   // row wrap, also after a width change
    c = col_pos;
    if (c == 0) begin
      lbl_left = '0;
      lbl_upleft = '0;
    end
    up  = lbl_line[c];
    ur  = (c + 1 < w) ? lbl_line[c+1] : '0;
    cur = '0;
    if (px.set) begin
      // priority: left < up < upper-left
      if (lbl_left != 0) cur = lbl_left;
      if (up != 0) cur = up;
      if (lbl_upleft != 0) cur = lbl_upleft;
      if (ur != 0 && ur != cur) begin
        if (cur != 0) begin
          // merge: relabel every copy of the upper-right label
          foreach (lbl_line[k]) if (lbl_line[k] == ur) lbl_line[k] = cur;
          if (lbl_left == ur) lbl_left = cur;
          if (lbl_upleft == ur) lbl_upleft = cur;
          if (up == ur) up = cur;
          if (blobs != 0) blobs--;
        end else begin
          cur = ur;
        end
      end
      if (cur == 0) begin
        if (lbl_next != LABEL_MAX) lbl_next++;
        cur = lbl_next;
        if (blobs != COUNT_MAX) blobs++;
      end
    end
    lbl_line[c] = cur;
    lbl_left = cur;
    lbl_upleft = up;
    if (px.last) begin
      count_q.push_back(blobs);
      clear_labels();
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Pixel driver: holds an offered transfer until taken, random gaps.
  // ---------------------------------------------------------------------
  int     gap_left = 0;
  pixel_t cur_px;

  always @(posedge clk) begin
    bit     nv;
    pixel_t np;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) count_pixel(cur_px);
      nv = 1'b0;
      np = cur_px;
      if (in_tvalid && !in_tready) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pixel_q.size() > 0 && !paused) begin
        np = pixel_q.pop_front();
        nv = 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 4);
      end
      cur_px    <= np;
      in_tvalid <= nv;
      in_tdata  <= {7'b0, np.set};
      in_tlast  <= np.last;
    end
  end

  // ---------------------------------------------------------------------
  // Count sink: checks each transfer, random stalls and the long hold-off.
  // ---------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    count_t exp_cnt;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (count_q.size() == 0) begin
          $display("%0t: unexpected count %0d", $realtime, out_tdata[19:0]);
          errors++;
        end else begin
          exp_cnt = count_q.pop_front();
          if (out_tdata[19:0] !== exp_cnt || out_tdata[23:20] !== 4'b0) begin
            $display("%0t: count mismatch, expected %0d actual 0x%06h",
                     $realtime, exp_cnt, out_tdata);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(0, 3);   // low now and while stall_left counts down
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  task automatic write_width(int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= WID_BITS'(v);
    width_reg  = WID_BITS'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every pixel is taken and every count is back
  task automatic drain();
    do @(negedge clk);
    while (pixel_q.size() > 0 || in_tvalid || count_q.size() > 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic push_px(bit s, bit l);
    pixel_t p;
    p.set = s;
    p.last = l;
    pixel_q.push_back(p);
  endtask

  // nfr frames of up to maxlen pixels; open_end leaves the last one running
  task automatic push_frames(int nfr, int maxlen, bit open_end);
    int len, dens;
    for (int f = 0; f < nfr; f++) begin
      len  = $urandom_range(1, maxlen);
      dens = $urandom_range(10, 90);
      for (int k = 0; k < len; k++)
        push_px($urandom_range(0, 99) < dens,
                (k == len - 1) && !(open_end && f == nfr - 1));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    width_reg = WID_BITS'(MAX_COLS);
    clear_labels();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: width 4
    write_width(4);
    push_px(0, 1);                                  // empty frame
    push_px(1, 1);                                  // lone pixel
    // two blobs joined by a diagonal bridge: 1 0 1 0 / 0 1 0 0
    push_px(1, 0); push_px(0, 0); push_px(1, 0); push_px(0, 0);
    push_px(0, 0); push_px(1, 0); push_px(0, 0); push_px(0, 1);
    // full frame of set pixels
    repeat (7) push_px(1, 0);
    push_px(1, 1);
    drain();

    // width zero counts as one column; above the limit clamps
    write_width(0);
    push_px(1, 0); push_px(1, 0); push_px(0, 0); push_px(1, 1);
    drain();
    write_width(2047);
    push_frames(2, 40, 0);
    drain();

    // widest line, one frame a little over a row
    write_width(MAX_COLS);
    for (int k = 0; k < 1030; k++) push_px($urandom_range(0, 3) == 0, k == 1029);
    drain();

    // narrow widths, a width change in the middle of a frame
    write_width(1);
    push_frames(4, 12, 0);
    drain();
    write_width(5);
    push_frames(3, 20, 1);
    drain();
    write_width(3);
    push_frames(3, 20, 0);
    drain();

    // long receiver hold-off with many short frames queued behind it
    write_width(2);
    hold_left = HOLD_CYCLES;
    push_frames(20, 4, 0);
    drain();

    // random widths
    for (int ph = 0; ph < 4; ph++) begin
      write_width($urandom_range(1, 16));
      push_frames($urandom_range(1, 3), 12, $urandom_range(0, 3) == 0);
      drain();
    end

    // sender pause mid-stream until all counts are in
    push_frames(5, 20, 0);
    half_q = pixel_q.size() / 2;
    while (pixel_q.size() > half_q) @(negedge clk);
    paused = 1;
    do @(negedge clk);
    while (in_tvalid || count_q.size() > 0);
    paused = 0;
    drain();

    // final stretch without idling
    quiet = 1;
    write_width(8);
    push_frames(6, 20, 0);
    drain();

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cb_pkg.sv
src/cb_cell.sv
src/count_8connected_blobs.sv
sim/testbench.sv
